### rtl/core/ste_pkg.sv
// Shared types and constants of the symbol table engine.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package ste_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TYPE_W   = 64;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned DATA_W   = TYPE_W + ADDR_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_MODIFY = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

### rtl/core/ste_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ste_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/symbol_table_engine.sv
// Symbol table engine: one command beat in, one result beat out. Depends on ste_pkg, ste_ram.
// A scan without a match reads every stored entry; a match ends the scan at its slot (a search then
// fetches its data word), and an insert into a full table or an unused opcode skips the scan; a
// stalled result beat holds the block further. One item at a time: a new command beat is taken
// only once the result of the last has gone to the output register. Synchronous reset empties the
// table; RAMs keep data.
`default_nettype none

module symbol_table_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ste_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [ste_pkg::KEY_W-1:0]     in_key,
  input  wire logic [ste_pkg::TYPE_W-1:0]    in_type_word,
  input  wire logic [ste_pkg::ADDR_W-1:0]    in_mem_address,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ste_pkg::STATUS_W-1:0]  out_status,
  output logic      [ste_pkg::INDEX_W-1:0]   out_index,
  output logic      [ste_pkg::TYPE_W-1:0]    out_found_type,
  output logic      [ste_pkg::ADDR_W-1:0]    out_found_address
);

  // Slot addresses need AW bits; the pointer and the count must also hold DEPTH.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Latched command
  logic [ste_pkg::OP_W-1:0]   opcode_r, opcode_nxt;
  logic [ste_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [ste_pkg::TYPE_W-1:0] type_r, type_nxt;
  logic [ste_pkg::ADDR_W-1:0] addr_r, addr_nxt;

  // Scan control: ptr_r is the next slot to read, cmp_* tracks the key
  // whose read data is arriving in this cycle.
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Finished result, waiting for the output register
  logic [ste_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ste_pkg::INDEX_W-1:0]  res_index_r, res_index_nxt;
  logic [ste_pkg::TYPE_W-1:0]   res_type_r, res_type_nxt;
  logic [ste_pkg::ADDR_W-1:0]   res_addr_r, res_addr_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [ste_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ste_pkg::INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [ste_pkg::TYPE_W-1:0]   out_type_r, out_type_nxt;
  logic [ste_pkg::ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  // RAM ports
  logic                        key_wr_en;
  logic [AW-1:0]               key_wr_addr;
  logic                        key_rd_en;
  logic [ste_pkg::KEY_W-1:0]   key_rd_data;
  logic                        data_wr_en;
  logic [AW-1:0]               data_wr_addr;
  logic [ste_pkg::DATA_W-1:0]  data_wr_data;
  logic                        data_rd_en;
  logic [ste_pkg::DATA_W-1:0]  data_rd_data;

  logic in_beat;
  logic hit;
  logic out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign hit      = cmp_vld_r && (key_rd_data == key_r);
  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Keys are read at the scan pointer; new keys are always appended at the count.
  assign key_wr_addr  = count_r[AW-1:0];
  assign data_wr_data = {type_r, addr_r};

  ste_ram #(
    .WIDTH (ste_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_r),
    .rd_en   (key_rd_en),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (key_rd_data)
  );

  ste_ram #(
    .WIDTH (ste_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_wr_en),
    .wr_addr (data_wr_addr),
    .wr_data (data_wr_data),
    .rd_en   (data_rd_en),
    .rd_addr (cmp_idx_r),
    .rd_data (data_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    opcode_nxt     = opcode_r;
    key_nxt        = key_r;
    type_nxt       = type_r;
    addr_nxt       = addr_r;
    ptr_nxt        = ptr_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_type_nxt   = res_type_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_type_nxt   = out_type_r;
    out_addr_nxt   = out_addr_r;
    key_wr_en      = 1'b0;
    key_rd_en      = 1'b0;
    data_wr_en     = 1'b0;
    data_wr_addr   = cmp_idx_r;
    data_rd_en     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          opcode_nxt     = in_opcode;
          key_nxt        = in_key;
          type_nxt       = in_type_word;
          addr_nxt       = in_mem_address;
          ptr_nxt        = '0;
          res_status_nxt = ste_pkg::ST_OK;
          res_index_nxt  = '0;
          res_type_nxt   = '0;
          res_addr_nxt   = '0;
          case (in_opcode)
            ste_pkg::OP_INSERT: begin
              // The full check comes before any duplicate search.
              if (count_r == CW'(DEPTH)) begin
                res_status_nxt = ste_pkg::ST_FULL;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ste_pkg::OP_SEARCH,
            ste_pkg::OP_MODIFY: begin
              state_nxt = S_SCAN;
            end
            default: begin
              // An unused opcode leaves the table alone and answers with zeros.
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_index_nxt = ste_pkg::INDEX_W'(cmp_idx_r);
          case (opcode_r)
            ste_pkg::OP_INSERT: begin
              res_status_nxt = ste_pkg::ST_DUP;
              state_nxt      = S_RESP;
            end
            ste_pkg::OP_SEARCH: begin
              data_rd_en = 1'b1;
              state_nxt  = S_FETCH;
            end
            default: begin
              // Modify: overwrite the data word of the first match.
              data_wr_en = 1'b1;
              state_nxt  = S_RESP;
            end
          endcase
        end else if (ptr_r < count_r) begin
          key_rd_en   = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else begin
          // Every stored key has been compared without a match.
          state_nxt = S_RESP;
          if (opcode_r == ste_pkg::OP_INSERT) begin
            key_wr_en     = 1'b1;
            data_wr_en    = 1'b1;
            data_wr_addr  = count_r[AW-1:0];
            res_index_nxt = ste_pkg::INDEX_W'(count_r);
            count_nxt     = count_r + CW'(1);
          end else begin
            res_status_nxt = ste_pkg::ST_NOTFOUND;
          end
        end
      end

      S_FETCH: begin
        res_type_nxt = data_rd_data[ste_pkg::DATA_W-1:ste_pkg::ADDR_W];
        res_addr_nxt = data_rd_data[ste_pkg::ADDR_W-1:0];
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          out_type_nxt   = res_type_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    opcode_r     <= opcode_nxt;
    key_r        <= key_nxt;
    type_r       <= type_nxt;
    addr_r       <= addr_nxt;
    ptr_r        <= ptr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_type_r   <= res_type_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_type_r   <= out_type_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_index         = out_index_r;
  assign out_found_type    = out_type_r;
  assign out_found_address = out_addr_r;

endmodule

`default_nettype wire

### rtl/core/ste_chk.sv
// Port-level checker for the symbol table engine, bound to the top level.
// Depends on ste_pkg.
`default_nettype none

module ste_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ste_pkg::STATUS_W-1:0]  out_status,
  input wire logic [ste_pkg::INDEX_W-1:0]   out_index,
  input wire logic [ste_pkg::TYPE_W-1:0]    out_found_type,
  input wire logic [ste_pkg::ADDR_W-1:0]    out_found_address
);

  // A held result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_index)
      && $stable(out_found_type) && $stable(out_found_address))
    else $error("result beat changed while stalled");

  // One command at a time: an accepted beat makes the block busy.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while the previous one is in progress");

  // A result with a failing status returns no stored data.
  a_no_data_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ste_pkg::ST_OK) |->
      (out_found_type == '0) && (out_found_address == '0))
    else $error("data returned with a failing status");

  // A full or not-found result carries no slot.
  a_no_index_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ste_pkg::ST_FULL) || (out_status == ste_pkg::ST_NOTFOUND))
      |-> (out_index == '0))
    else $error("slot reported for a full or not-found result");

endmodule

bind symbol_table_engine ste_chk u_ste_chk (.*);

`default_nettype wire

### sim/ste_scoreboard_pkg.sv
// Scoreboard for the symbol table engine testbench: a predictor that keeps
// its own copy of the table and a queue of the result beats still due.
// Depends on ste_pkg.
package ste_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  // The fourth opcode has no meaning; the block must answer it with zeros.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_t              status;
    logic [INDEX_W-1:0]   index;
    logic [TYPE_W-1:0]    found_type;
    logic [ADDR_W-1:0]    found_address;
  } table_reply_t;

  class symbol_table_scoreboard #(int unsigned DEPTH = 64);
    logic [KEY_W-1:0]  key_tbl  [DEPTH];
    logic [TYPE_W-1:0] type_tbl [DEPTH];
    logic [ADDR_W-1:0] addr_tbl [DEPTH];
    int unsigned       used;
    table_reply_t      replies_due [$];
    int unsigned       errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    // First slot below the fill level holding this key, or -1.
    function int lookup(logic [KEY_W-1:0] key);
      for (int i = 0; i < int'(used); i++) begin
        if (key_tbl[i] == key) begin
          return i;
        end
      end
      return -1;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // Applies one accepted command beat to the table copy and queues its reply.
    function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [TYPE_W-1:0] type_word,
                               logic [ADDR_W-1:0] mem_address);
      table_reply_t reply;
      int           slot;
      reply = '{status: ST_OK, index: '0, found_type: '0, found_address: '0};
      slot  = lookup(key);
      case (op)
        OP_INSERT: begin
          if (used >= DEPTH) begin
            reply.status = ST_FULL;
          end else if (slot >= 0) begin
            reply.status = ST_DUP;
            reply.index  = slot[INDEX_W-1:0];
          end else begin
            reply.index    = used[INDEX_W-1:0];
            key_tbl[used]  = key;
            type_tbl[used] = type_word;
            addr_tbl[used] = mem_address;
            used++;
          end
        end
        OP_SEARCH: begin
          if (slot < 0) begin
            reply.status = ST_NOTFOUND;
          end else begin
            reply.index         = slot[INDEX_W-1:0];
            reply.found_type    = type_tbl[slot];
            reply.found_address = addr_tbl[slot];
          end
        end
        OP_MODIFY: begin
          if (slot < 0) begin
            reply.status = ST_NOTFOUND;
          end else begin
            reply.index    = slot[INDEX_W-1:0];
            type_tbl[slot] = type_word;
            addr_tbl[slot] = mem_address;
          end
        end
        default: begin
        end
      endcase
      replies_due.push_back(reply);
    endfunction

    // Compares one accepted result beat with the oldest reply still due.
    function void check_result(status_t status, logic [INDEX_W-1:0] index,
                               logic [TYPE_W-1:0] found_type,
                               logic [ADDR_W-1:0] found_address);
      table_reply_t due;
      if (replies_due.size() == 0) begin
        $display("%t: result beat with no reply due (status %0d index %0d)",
                 $realtime, status, index);
        errors++;
        return;
      end
      due = replies_due.pop_front();
      if (status !== due.status) begin
        $display("%t: status mismatch, expected %0d actual %0d",
                 $realtime, due.status, status);
        errors++;
      end
      if (index !== due.index) begin
        $display("%t: index mismatch, expected %0d actual %0d",
                 $realtime, due.index, index);
        errors++;
      end
      if (found_type !== due.found_type) begin
        $display("%t: found_type mismatch, expected %h actual %h",
                 $realtime, due.found_type, found_type);
        errors++;
      end
      if (found_address !== due.found_address) begin
        $display("%t: found_address mismatch, expected %h actual %h",
                 $realtime, due.found_address, found_address);
        errors++;
      end
    endfunction
  endclass

endpackage

### sim/symbol_table_engine_tb.sv
// Top level of the symbol table engine testbench: clock, reset, command and
// result drivers, a directed opening and a long random run.
// Depends on ste_pkg, ste_tb_pkg and the symbol_table_engine RTL.
module symbol_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;
  import ste_tb_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1900;
  // The slowest beat is a full-table scan plus the longest result stall and
  // the longest sender gap; the limit is several times that over the run.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Quiet time after the last reply, enough for a full scan to surface.
  localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 16;

  localparam logic [KEY_W-1:0] ALT_A_WORD = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [KEY_W-1:0] ALT_5_WORD = 64'h5555_5555_5555_5555;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode      = '0;
  logic [KEY_W-1:0]     in_key         = '0;
  logic [TYPE_W-1:0]    in_type_word   = '0;
  logic [ADDR_W-1:0]    in_mem_address = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [INDEX_W-1:0]   out_index;
  logic [TYPE_W-1:0]    out_found_type;
  logic [ADDR_W-1:0]    out_found_address;

  ste_tb_pkg::symbol_table_scoreboard #(TABLE_DEPTH) sb = new();
  int unsigned cycle_count = 0;

  always #4 clk = ~clk;

  symbol_table_engine #(
    .DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_key           (in_key),
    .in_type_word     (in_type_word),
    .in_mem_address   (in_mem_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_index        (out_index),
    .out_found_type   (out_found_type),
    .out_found_address(out_found_address)
  );

  // Presents one command beat and holds it until the block takes it. It is
  // always entered just after a rising edge, so valid set here is seen at the
  // next edge; the stall sampled straight after an edge is its pre-edge value.
  task automatic send_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [TYPE_W-1:0] type_word,
                              logic [ADDR_W-1:0] mem_address);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_key         <= key;
    in_type_word   <= type_word;
    in_mem_address <= mem_address;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, key, type_word, mem_address);
  endtask

  // Drops valid for a gap between bursts; a zero gap keeps the beats flowing.
  task automatic pause_sender(int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds the sender back until every reply due has been seen.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // A short identifier of one to eight characters, zero padded, as a
  // compiler front end would hand it over.
  function automatic logic [63:0] random_name();
    logic [63:0] name;
    int unsigned len;
    name = '0;
    len  = $urandom_range(1, 8);
    for (int i = 0; i < int'(len); i++) begin
      case ($urandom_range(0, 9))
        0:       name[8*i +: 8] = 8'h5F;
        1:       name[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
        default: name[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
      endcase
    end
    return name;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    return sb.key_tbl[$urandom_range(0, sb.used - 1)];
  endfunction

  // One random command. Searches and modifies mostly name keys already in
  // the table so that hits dominate; near misses differ by a single bit.
  // Inserts mix fresh names with duplicates, which keeps the table filling
  // steadily and then exercises the full table for the rest of the run.
  task automatic random_command();
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] type_word;
    logic [ADDR_W-1:0] mem_address;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 28) begin
      op = OP_INSERT;
    end else if (roll < 60) begin
      op = OP_SEARCH;
    end else if (roll < 96) begin
      op = OP_MODIFY;
    end else begin
      op = OP_UNUSED;
    end
    roll = $urandom_range(0, 99);
    if (sb.used != 0 && roll < ((op == OP_INSERT) ? 45 : 70)) begin
      key = stored_key();
    end else if (sb.used != 0 && roll < 85) begin
      key = stored_key() ^ (64'd1 << $urandom_range(0, 63));
    end else if (roll < 93) begin
      key = random_name();
    end else begin
      key = random_word();
    end
    type_word   = $urandom_range(0, 1) ? random_name() : random_word();
    mem_address = $urandom_range(0, 1) ? $urandom() : ($urandom() & 32'hFFFF_FFFC);
    send_command(op, key, type_word, mem_address);
  endtask

  // Result side: every accepted beat goes to the scoreboard. Sampling just
  // after the edge sees the values that the edge itself transferred.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(status_t'(out_status), out_index, out_found_type,
                      out_found_address);
    end
  end

  // The receiver stalls on a pattern of its own: clear stretches, light and
  // heavy random stalling, and now and then a solid stall.
  initial begin
    int unsigned mode;
    int unsigned span;
    wait (rst_n);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(4, 60);
      repeat (span) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run that never settles is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          held_once;
    sent      = 0;
    held_once = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. The empty table must miss on both search and modify,
    // and the meaningless opcode must answer with zeros.
    send_command(OP_SEARCH, '0, '0, '0);
    send_command(OP_MODIFY, '0, '1, '1);
    send_command(OP_UNUSED, '1, '1, '1);
    // A key of zero is an ordinary key; the extremes of every field go in.
    send_command(OP_INSERT, '0, '1, '1);
    send_command(OP_INSERT, '1, '0, '0);
    // A duplicate insert stores nothing and points at the existing slot.
    send_command(OP_INSERT, '0, 64'("int"), 32'h0000_1000);
    send_command(OP_SEARCH, '0, '0, '0);
    send_command(OP_SEARCH, '1, '0, '0);
    send_command(OP_MODIFY, '1, 64'("uint32_t"), 32'h8000_0000);
    send_command(OP_SEARCH, '1, '1, '1);
    send_command(OP_INSERT, 64'("counter"), 64'("int"), 32'h0000_0004);
    send_command(OP_INSERT, ALT_A_WORD, ALT_5_WORD, 32'h5555_5555);
    send_command(OP_INSERT, ALT_5_WORD, ALT_A_WORD, 32'hAAAA_AAAA);
    send_command(OP_SEARCH, ALT_5_WORD, '0, '0);
    send_command(OP_SEARCH, ALT_A_WORD, '0, '0);
    send_command(OP_MODIFY, 64'("missing"), 64'("char"), 32'h0000_0040);
    // The meaningless opcode on a stored key must leave that entry alone.
    send_command(OP_UNUSED, 64'("counter"), 64'("char"), 32'h0000_1234);
    send_command(OP_SEARCH, 64'("counter"), '0, '0);
    send_command(OP_MODIFY, '0, '0, '0);
    send_command(OP_SEARCH, '0, '1, '1);
    send_command(OP_INSERT, 64'h1, 64'("float"), 32'h0000_0001);
    send_command(OP_SEARCH, 64'h8000_0000_0000_0000, '0, '0);
    send_command(OP_SEARCH, 64'h1, '0, '0);
    drain_replies();

    // Random run in bursts of varying length with varying gaps; a zero gap
    // joins two bursts into one unbroken stretch. Half way through the
    // sender holds back once until every reply due has come home.
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < RANDOM_ITEMS) begin
        random_command();
        burst--;
        sent++;
      end
      if (!held_once && sent >= RANDOM_ITEMS / 2) begin
        drain_replies();
        held_once = 1'b1;
      end else begin
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### symbol_table_engine.f
rtl/core/ste_pkg.sv
rtl/core/ste_ram.sv
rtl/core/symbol_table_engine.sv
rtl/core/ste_chk.sv
sim/ste_scoreboard_pkg.sv
sim/symbol_table_engine_tb.sv
